@@ design/iedf_pkg.sv @@
`default_nettype none
package iedf_pkg;

  localparam int PAYLOAD_W = 40;
  localparam int LABEL_W   = 32;
  localparam int KEY_W     = 8;

  localparam logic [1:0] REQ_EVENT     = 2'd0;
  localparam logic [1:0] REQ_POP_KEY   = 2'd1;
  localparam logic [1:0] REQ_POP_MOUSE = 2'd2;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  localparam logic [LABEL_W-1:0] LABEL_KEY   = 32'd1;
  localparam logic [LABEL_W-1:0] LABEL_MOUSE = 32'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY_PUSH,
    OP_MOUSE_PUSH,
    OP_KEY_POP,
    OP_MOUSE_POP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [PAYLOAD_W-1:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_KEY_READ,
    BK_MOUSE_READ
  } back_state_t;

  typedef struct packed {
    logic               available;
    logic               dropped;
    logic [6:0]         scancode;
    logic               pressed;
    logic [7:0]         buttons;
    logic signed [11:0] delta_x;
    logic signed [11:0] delta_y;
    logic signed [7:0]  delta_wheel;
  } res_t;

  typedef struct packed {
    logic key_empty;
    logic key_full;
    logic mouse_empty;
    logic mouse_full;
  } back_stat_t;

endpackage
`default_nettype wire

@@ design/iedf_in_if.sv @@
`default_nettype none
interface iedf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] label;
  logic [39:0] payload;

  modport source (output valid, req_type, label, payload, input ready);
  modport sink   (input valid, req_type, label, payload, output ready);
endinterface
`default_nettype wire

@@ design/iedf_out_if.sv @@
`default_nettype none
interface iedf_out_if;
  logic               valid;
  logic               ready;
  logic               available;
  logic               dropped;
  logic [6:0]         scancode;
  logic               pressed;
  logic [7:0]         buttons;
  logic signed [11:0] delta_x;
  logic signed [11:0] delta_y;
  logic signed [7:0]  delta_wheel;

  modport source (output valid, available, dropped, scancode, pressed, buttons,
                  delta_x, delta_y, delta_wheel, input ready);
  modport sink   (input valid, available, dropped, scancode, pressed, buttons,
                  delta_x, delta_y, delta_wheel, output ready);
endinterface
`default_nettype wire

@@ design/iedf_front.sv @@
`default_nettype none
module iedf_front (
  iedf_in_if.sink       req,
  output iedf_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import iedf_pkg::*;

  logic [7:0] raw;

  assign raw       = req.payload[7:0];
  assign cmd_valid = req.valid;
  assign req.ready = cmd_ready;

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.data = '0;
    unique case (req.req_type)
      REQ_EVENT: begin
        if (req.label == LABEL_KEY) begin
          // store pressed in bit 7: release flag inverted
          cmd.op   = OP_KEY_PUSH;
          cmd.data = {{(PAYLOAD_W-KEY_W){1'b0}}, ~raw[7], raw[6:0]};
        end else if (req.label == LABEL_MOUSE) begin
          cmd.op   = OP_MOUSE_PUSH;
          cmd.data = req.payload;
        end
      end
      REQ_POP_KEY:   cmd.op = OP_KEY_POP;
      REQ_POP_MOUSE: cmd.op = OP_MOUSE_POP;
      REQ_UNUSED:    cmd.op = OP_NONE;
      default:       cmd.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

@@ design/iedf_cmd_queue.sv @@
`default_nettype none
module iedf_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  iedf_pkg::cmd_t in_cmd,
  output logic           in_ready,
  output logic           out_valid,
  output iedf_pkg::cmd_t out_cmd,
  input  logic           out_ready
);
  import iedf_pkg::*;

  cmd_t       slots [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slots[rd_idx];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_idx <= ~wr_idx;
      if (pop)  rd_idx <= ~rd_idx;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_idx] <= in_cmd;
  end
endmodule
`default_nettype wire

@@ design/iedf_back.sv @@
`default_nettype none
module iedf_back #(
  parameter int KEY_DEPTH   = 64,
  parameter int MOUSE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  iedf_pkg::cmd_t       cmd,
  output logic                 cmd_ready,
  iedf_out_if.source           rsp,
  output iedf_pkg::back_stat_t stat
);
  import iedf_pkg::*;

  localparam int KEY_AW   = $clog2(KEY_DEPTH);
  localparam int MOUSE_AW = $clog2(MOUSE_DEPTH);

  logic [KEY_W-1:0]     key_mem   [KEY_DEPTH];
  logic [PAYLOAD_W-1:0] mouse_mem [MOUSE_DEPTH];
  logic [KEY_W-1:0]     key_rd_data;
  logic [PAYLOAD_W-1:0] mouse_rd_data;

  logic [KEY_AW-1:0]   key_wr;
  logic [KEY_AW-1:0]   key_rd;
  logic [MOUSE_AW-1:0] mouse_wr;
  logic [MOUSE_AW-1:0] mouse_rd;
  logic [KEY_AW-1:0]   key_wr_inc;
  logic [KEY_AW-1:0]   key_rd_inc;
  logic [MOUSE_AW-1:0] mouse_wr_inc;
  logic [MOUSE_AW-1:0] mouse_rd_inc;

  back_state_t state;
  back_state_t state_next;

  logic take;
  logic key_we;
  logic mouse_we;
  logic key_rd_adv;
  logic mouse_rd_adv;
  logic load_res;
  res_t res_next;
  res_t res;
  logic out_valid;

  assign key_wr_inc   = (key_wr == KEY_AW'(KEY_DEPTH - 1)) ? '0 : key_wr + 1'b1;
  assign key_rd_inc   = (key_rd == KEY_AW'(KEY_DEPTH - 1)) ? '0 : key_rd + 1'b1;
  assign mouse_wr_inc = (mouse_wr == MOUSE_AW'(MOUSE_DEPTH - 1)) ? '0 : mouse_wr + 1'b1;
  assign mouse_rd_inc = (mouse_rd == MOUSE_AW'(MOUSE_DEPTH - 1)) ? '0 : mouse_rd + 1'b1;

  assign stat.key_empty   = (key_rd == key_wr);
  assign stat.key_full    = (key_wr_inc == key_rd);
  assign stat.mouse_empty = (mouse_rd == mouse_wr);
  assign stat.mouse_full  = (mouse_wr_inc == mouse_rd);

  // one command at a time, and only while the result register is free
  assign cmd_ready = (state == BK_IDLE) && !out_valid;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take && cmd.op == OP_KEY_POP && !stat.key_empty)
          state_next = BK_KEY_READ;
        else if (take && cmd.op == OP_MOUSE_POP && !stat.mouse_empty)
          state_next = BK_MOUSE_READ;
      end
      BK_KEY_READ:   state_next = BK_IDLE;
      BK_MOUSE_READ: state_next = BK_IDLE;
      default:       state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    key_we       = 1'b0;
    mouse_we     = 1'b0;
    key_rd_adv   = 1'b0;
    mouse_rd_adv = 1'b0;
    load_res     = 1'b0;
    res_next     = '0;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          unique case (cmd.op)
            OP_KEY_PUSH: begin
              load_res         = 1'b1;
              res_next.dropped = stat.key_full;
              key_we           = !stat.key_full;
            end
            OP_MOUSE_PUSH: begin
              load_res         = 1'b1;
              res_next.dropped = stat.mouse_full;
              mouse_we         = !stat.mouse_full;
            end
            // a pop of a nonempty queue answers from the read state
            OP_KEY_POP:   load_res = stat.key_empty;
            OP_MOUSE_POP: load_res = stat.mouse_empty;
            OP_NONE:      load_res = 1'b1;
            default:      load_res = 1'b1;
          endcase
        end
      end
      BK_KEY_READ: begin
        load_res           = 1'b1;
        key_rd_adv         = 1'b1;
        res_next.available = 1'b1;
        res_next.scancode  = key_rd_data[6:0];
        res_next.pressed   = key_rd_data[7];
      end
      BK_MOUSE_READ: begin
        load_res             = 1'b1;
        mouse_rd_adv         = 1'b1;
        res_next.available   = 1'b1;
        res_next.buttons     = mouse_rd_data[7:0];
        res_next.delta_x     = $signed(mouse_rd_data[19:8]);
        res_next.delta_y     = $signed(mouse_rd_data[31:20]);
        res_next.delta_wheel = $signed(mouse_rd_data[39:32]);
      end
      default: load_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      key_wr    <= '0;
      key_rd    <= '0;
      mouse_wr  <= '0;
      mouse_rd  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (key_we)       key_wr   <= key_wr_inc;
      if (key_rd_adv)   key_rd   <= key_rd_inc;
      if (mouse_we)     mouse_wr <= mouse_wr_inc;
      if (mouse_rd_adv) mouse_rd <= mouse_rd_inc;
      if (load_res)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wr] <= cmd.data[KEY_W-1:0];
    key_rd_data <= key_mem[key_rd];
  end

  always_ff @(posedge clk) begin
    if (mouse_we) mouse_mem[mouse_wr] <= cmd.data;
    mouse_rd_data <= mouse_mem[mouse_rd];
  end

  assign rsp.valid       = out_valid;
  assign rsp.available   = res.available;
  assign rsp.dropped     = res.dropped;
  assign rsp.scancode    = res.scancode;
  assign rsp.pressed     = res.pressed;
  assign rsp.buttons     = res.buttons;
  assign rsp.delta_x     = res.delta_x;
  assign rsp.delta_y     = res.delta_y;
  assign rsp.delta_wheel = res.delta_wheel;
endmodule
`default_nettype wire

@@ design/input_event_decode_dual_fifo_top.sv @@
`default_nettype none
// Channel | Dir | Beat contents
// req     | in  | req_type, label, payload
// rsp     | out | available, dropped, scancode, pressed, buttons, delta_x/y, delta_wheel
//
// Each req beat gives one rsp beat, in order, through a two-entry command queue.
// The executor answers a push, an ignored item or a pop of an empty queue from idle,
// and a pop of a nonempty queue from a read state (registered memory read); the
// result register must empty before the next command starts, so no new command is
// taken until rsp accepts the last result. req stays ready while the command queue has room.
// Reset clears the pointers and control; the queue memories hold no reset.
module input_event_decode_dual_fifo_top #(
  parameter int KEY_DEPTH   = 64,
  parameter int MOUSE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  iedf_in_if.sink    req,
  iedf_out_if.source rsp
);
  import iedf_pkg::*;

  cmd_t       f_cmd;
  logic       f_valid;
  logic       f_ready;
  cmd_t       q_cmd;
  logic       q_valid;
  logic       q_ready;
  back_stat_t stat;

  iedf_front u_front (
    .req       (req),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  iedf_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  iedf_back #(
    .KEY_DEPTH   (KEY_DEPTH),
    .MOUSE_DEPTH (MOUSE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .rsp       (rsp),
    .stat      (stat)
  );

  a_key_ptrs: assert property (@(posedge clk) disable iff (rst)
    !(stat.key_empty && stat.key_full))
    else $error("key queue both empty and full");

  a_mouse_ptrs: assert property (@(posedge clk) disable iff (rst)
    !(stat.mouse_empty && stat.mouse_full))
    else $error("mouse queue both empty and full");

  a_stall_has_cmd: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> q_valid)
    else $error("input stalled with no queued command");

  a_avail_no_drop: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.available |-> !rsp.dropped)
    else $error("popped result flagged as dropped");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.available |->
      rsp.scancode == 7'd0 && !rsp.pressed && rsp.buttons == 8'd0 &&
      rsp.delta_x == 12'sd0 && rsp.delta_y == 12'sd0 && rsp.delta_wheel == 8'sd0)
    else $error("non-pop result carries entry fields");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb;
  import iedf_pkg::*;

  localparam int KEY_DEPTH    = 64;
  localparam int MOUSE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  localparam logic [39:0] ALL_ONES = {40{1'b1}};
  localparam res_t        ZERO_RES = '0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] label;
    logic [39:0] payload;
  } beat_t;

  typedef struct {
    beat_t beat;
    bit    typed;
    res_t  want;
  } script_row_t;

  typedef enum {SEG_KEY_FILL, SEG_MOUSE_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

  logic clk;
  logic rst;

  iedf_in_if  req_ch ();
  iedf_out_if rsp_ch ();

  input_event_decode_dual_fifo_top #(
    .KEY_DEPTH   (KEY_DEPTH),
    .MOUSE_DEPTH (MOUSE_DEPTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of both event rings.
  logic [7:0]  key_ring [KEY_DEPTH];
  logic [39:0] mouse_ring [MOUSE_DEPTH];
  int unsigned key_wr = 0;
  int unsigned key_rd = 0;
  int unsigned mouse_wr = 0;
  int unsigned mouse_rd = 0;

  res_t        pending_results [$];
  int          failures = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic res_t key_pop_res(logic [6:0] code, logic pressed);
    res_t r;
    r = '0;
    r.available = 1'b1;
    r.scancode  = code;
    r.pressed   = pressed;
    return r;
  endfunction

  function automatic res_t mouse_pop_res(logic [7:0] btn, logic signed [11:0] dx,
                                         logic signed [11:0] dy, logic signed [7:0] dz);
    res_t r;
    r = '0;
    r.available   = 1'b1;
    r.buttons     = btn;
    r.delta_x     = dx;
    r.delta_y     = dy;
    r.delta_wheel = dz;
    return r;
  endfunction

  // Apply one request to the shadow rings and return the response it earns.
  function automatic res_t event_queue_step(beat_t b);
    res_t        r;
    int unsigned nxt;
    logic [7:0]  k;
    logic [39:0] m;
    r = '0;
    case (b.req_type)
      REQ_EVENT: begin
        if (b.label == LABEL_KEY) begin
          nxt = (key_wr + 1) % KEY_DEPTH;
          if (nxt == key_rd) begin
            r.dropped = 1'b1;
          end else begin
            // bit 7 of the stored entry is "pressed", the inverse of the release bit
            key_ring[key_wr] = {~b.payload[7], b.payload[6:0]};
            key_wr = nxt;
          end
        end else if (b.label == LABEL_MOUSE) begin
          nxt = (mouse_wr + 1) % MOUSE_DEPTH;
          if (nxt == mouse_rd) begin
            r.dropped = 1'b1;
          end else begin
            mouse_ring[mouse_wr] = b.payload;
            mouse_wr = nxt;
          end
        end
      end
      REQ_POP_KEY: begin
        if (key_rd != key_wr) begin
          k = key_ring[key_rd];
          r = key_pop_res(k[6:0], k[7]);
          key_rd = (key_rd + 1) % KEY_DEPTH;
        end
      end
      REQ_POP_MOUSE: begin
        if (mouse_rd != mouse_wr) begin
          m = mouse_ring[mouse_rd];
          r = mouse_pop_res(m[7:0], m[19:8], m[31:20], m[39:32]);
          mouse_rd = (mouse_rd + 1) % MOUSE_DEPTH;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic beat_t random_beat(seg_kind_t seg);
    beat_t       b;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] lb;
    int unsigned pick;
    hi = $urandom;
    lo = $urandom;
    lb = $urandom;
    b.payload = {hi[7:0], lo};
    b.label   = lb;
    pick      = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise: any request type with a random label, so its events are mostly ignored
      b.req_type = 2'($urandom_range(0, 3));
      return b;
    end
    case (seg)
      SEG_KEY_FILL: begin
        b.req_type = (pick < 88) ? REQ_EVENT : REQ_POP_KEY;
        b.label    = LABEL_KEY;
      end
      SEG_MOUSE_FILL: begin
        b.req_type = (pick < 88) ? REQ_EVENT : REQ_POP_MOUSE;
        b.label    = LABEL_MOUSE;
      end
      SEG_DRAIN: begin
        b.req_type = (pick < 55) ? REQ_POP_KEY : REQ_POP_MOUSE;
      end
      default: begin
        case (pick % 4)
          0: begin b.req_type = REQ_EVENT; b.label = LABEL_KEY; end
          1: begin b.req_type = REQ_EVENT; b.label = LABEL_MOUSE; end
          2: b.req_type = REQ_POP_KEY;
          default: b.req_type = REQ_POP_MOUSE;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic script_row_t script_row(logic [1:0] rt, logic [31:0] lb,
                                             logic [39:0] pl, bit typed, res_t want);
    script_row_t s;
    s.beat.req_type = rt;
    s.beat.label    = lb;
    s.beat.payload  = pl;
    s.typed         = typed;
    s.want          = want;
    return s;
  endfunction

  function automatic string show_res(res_t r);
    return $sformatf("avail=%0b drop=%0b code=%h pressed=%0b btn=%h dx=%0d dy=%0d wheel=%0d",
                     r.available, r.dropped, r.scancode, r.pressed, r.buttons,
                     r.delta_x, r.delta_y, r.delta_wheel);
  endfunction

  task automatic log_failure(string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("tb: %s", msg);
  endtask

  // Present one request beat, hold it until accepted, then log its expected response.
  task automatic send_request(beat_t b, int unsigned gap, bit typed, res_t want);
    res_t model_res;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= b.req_type;
    req_ch.label    <= b.label;
    req_ch.payload  <= b.payload;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model_res = event_queue_step(b);
    pending_results.push_back(typed ? want : model_res);
  endtask

  // Response side: random stalls, compare every beat against the oldest expectation.
  initial begin
    int unsigned stall;
    bit          idle_on;
    int          beat_no;
    res_t        got;
    res_t        want;
    beat_no = 0;
    idle_on = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beat_no % 37 == 0) idle_on = ($urandom_range(0, 2) != 0);
      stall = idle_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got = {rsp_ch.available, rsp_ch.dropped, rsp_ch.scancode, rsp_ch.pressed,
             rsp_ch.buttons, rsp_ch.delta_x, rsp_ch.delta_y, rsp_ch.delta_wheel};
      if (pending_results.size() == 0) begin
        log_failure($sformatf("response beat %0d with nothing pending: %s",
                              beat_no, show_res(got)));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          log_failure($sformatf("response beat %0d mismatch\n  want %s\n  got  %s",
                                beat_no, show_res(want), show_res(got)));
      end
      beat_no++;
    end
  end

  initial begin
    script_row_t script [$];
    beat_t       b;
    seg_kind_t   seg;
    int unsigned seg_len;
    int unsigned gap;
    int unsigned useful;
    bit          idle_on;

    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_EVENT;
    req_ch.label    <= '0;
    req_ch.payload  <= '0;
    rsp_ch.ready    <= 1'b0;

    // empty pops, unused request, ignored labels
    script.push_back(script_row(REQ_POP_KEY,   '0, '0, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_POP_MOUSE, '0, '0, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_UNUSED, 32'hFFFF_FFFF, ALL_ONES, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, 32'h0, ALL_ONES, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, 32'hFFFF_FFFF, ALL_ONES, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, 32'd3, ALL_ONES, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, 32'h8000_0001, ALL_ONES, 1'b1, ZERO_RES));
    // key events: press and release at both code extremes, high payload bits ignored
    script.push_back(script_row(REQ_EVENT, LABEL_KEY, 40'h0, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, LABEL_KEY, ALL_ONES, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, LABEL_KEY, 40'h80, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, LABEL_KEY, 40'h7F, 1'b1, ZERO_RES));
    // mouse events: all ones, most negative, most positive
    script.push_back(script_row(REQ_EVENT, LABEL_MOUSE, ALL_ONES, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, LABEL_MOUSE,
                                {8'h80, 12'h800, 12'h800, 8'h00}, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_EVENT, LABEL_MOUSE,
                                {8'h7F, 12'h7FF, 12'h7FF, 8'hA5}, 1'b1, ZERO_RES));
    // drain both queues; label and payload of a pop are don't-care
    script.push_back(script_row(REQ_POP_KEY, '0, '0, 1'b1, key_pop_res(7'h00, 1'b1)));
    script.push_back(script_row(REQ_POP_KEY, 32'hFFFF_FFFF, ALL_ONES, 1'b1,
                                key_pop_res(7'h7F, 1'b0)));
    script.push_back(script_row(REQ_POP_MOUSE, 32'hFFFF_FFFF, ALL_ONES, 1'b1,
                                mouse_pop_res(8'hFF, 12'hFFF, 12'hFFF, 8'hFF)));
    script.push_back(script_row(REQ_POP_MOUSE, '0, '0, 1'b1,
                                mouse_pop_res(8'h00, 12'h800, 12'h800, 8'h80)));
    script.push_back(script_row(REQ_POP_KEY, '0, '0, 1'b1, key_pop_res(7'h00, 1'b0)));
    script.push_back(script_row(REQ_POP_KEY, '0, '0, 1'b1, key_pop_res(7'h7F, 1'b1)));
    script.push_back(script_row(REQ_POP_KEY, '0, '0, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_POP_MOUSE, '0, '0, 1'b0, ZERO_RES));
    script.push_back(script_row(REQ_POP_MOUSE, '0, '0, 1'b1, ZERO_RES));
    script.push_back(script_row(REQ_UNUSED, '0, '0, 1'b1, ZERO_RES));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      gap = (i % 3 == 0) ? 0 : $urandom_range(0, 17);
      send_request(script[i].beat, gap, script[i].typed, script[i].want);
    end

    // Random part in segments: fill runs can push a queue past full, drain runs can empty it.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      seg     = seg_kind_t'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 120);
      idle_on = ($urandom_range(0, 2) != 0);
      repeat (seg_len) begin
        b   = random_beat(seg);
        gap = idle_on ? $urandom_range(0, 17) : 0;
        send_request(b, gap, 1'b0, ZERO_RES);
        if (!(b.req_type == REQ_UNUSED ||
              (b.req_type == REQ_EVENT && b.label != LABEL_KEY && b.label != LABEL_MOUSE)))
          useful++;
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
